// ----- hw/rtl/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// Shared sizes and command codes for the positional list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  // List storage
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int unsigned CMD_W = 3;
  localparam int unsigned POS_W = 7;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned LEN_W = 7;

  // Common width for position / count compares
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_FIND   = 3'd4
  } cmd_e;

endpackage

`default_nettype wire

// ----- hw/rtl/ple_ram.sv -----
// ----------------------------------------------------------------------------
// ple_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. No reset on the array.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/positional_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Bounded ordered list with 1-based positions: append, insert, delete, read
// and find. Elements live in one RAM; insert and delete shift entries one per
// cycle through a read/write pipeline, find scans one entry per cycle.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | request   | in_valid_i / in_stall_o | cmd_i, position_i, value_i
//   out     | result    | out_valid_o/out_stall_i | ok_o, elem_out_o, found_pos_o,
//           |           |                         | list_len_o
//
// Insert and delete walk the shifted entries, and find the scanned entries (up to
//   CAPACITY), through the single RAM read port, one element per cycle; an insert
//   at the tail shifts nothing.
// One request at a time; the next is taken once the result sits in the output
//   register, which may still be waiting on out_stall_i.
// Reset empties the list at once; RAM contents are never cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [ple_pkg::CMD_W-1:0]  cmd_i,
  input  wire logic [ple_pkg::POS_W-1:0]  position_i,
  input  wire logic signed [ple_pkg::VAL_W-1:0] value_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            ok_o,
  output logic signed [ple_pkg::VAL_W-1:0] elem_out_o,
  output logic [ple_pkg::POS_W-1:0]       found_pos_o,
  output logic [ple_pkg::LEN_W-1:0]       list_len_o
);

  import ple_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_INS_SHIFT,
    ST_INS_PUT,
    ST_DEL_SHIFT,
    ST_FIND,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [VAL_W-1:0]   val_q, val_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;

  // result staging
  logic               res_ok_q, res_ok_d;
  logic [VAL_W-1:0]   res_elem_q, res_elem_d;
  logic [POS_W-1:0]   res_fpos_q, res_fpos_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic               ok_q, ok_d;
  logic [VAL_W-1:0]   elem_q, elem_d;
  logic [POS_W-1:0]   fpos_q, fpos_d;
  logic [LEN_W-1:0]   len_q, len_d;

  // RAM ports
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [VAL_W-1:0]   ram_wdata, ram_rdata;

  // position / count helpers
  logic [CMP_W-1:0]   pos_x, cnt_x;
  logic [ADDR_W-1:0]  pos_m1, cnt_m1;
  logic               full, pos_in, ins_ok, out_free;

  assign pos_x    = CMP_W'(pos_q);
  assign cnt_x    = CMP_W'(count_q);
  assign pos_m1   = ADDR_W'(pos_x - CMP_W'(1));
  assign cnt_m1   = ADDR_W'(cnt_x - CMP_W'(1));
  assign full     = (cnt_x >= CMP_W'(CAPACITY));
  assign pos_in   = (pos_x != '0) && (pos_x <= cnt_x);
  assign ins_ok   = !full && (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
  assign out_free = !out_valid_q || !out_stall_i;

  ple_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next-state logic
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    pos_d       = pos_q;
    val_d       = val_q;
    count_d     = count_q;
    idx_d       = idx_q;
    res_ok_d    = res_ok_q;
    res_elem_d  = res_elem_q;
    res_fpos_d  = res_fpos_q;
    out_valid_d = out_valid_q && out_stall_i;
    ok_d        = ok_q;
    elem_d      = elem_q;
    fpos_d      = fpos_q;
    len_d       = len_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          pos_d   = position_i;
          val_d   = value_i;
          state_d = ST_EXEC;
        end
      end

      // decode and check the request, start the RAM walk where one is needed
      ST_EXEC: begin
        res_ok_d   = 1'b0;
        res_elem_d = '0;
        res_fpos_d = '0;
        state_d    = ST_DONE;
        case (cmd_q)
          CMD_APPEND: begin
            if (!full) begin
              ram_we    = 1'b1;
              ram_waddr = ADDR_W'(count_q);
              ram_wdata = val_q;
              count_d   = count_q + CNT_W'(1);
              res_ok_d  = 1'b1;
            end
          end
          CMD_INSERT: begin
            if (ins_ok) begin
              if (pos_x == cnt_x + CMP_W'(1)) begin
                // insert at the tail: nothing to move
                ram_we    = 1'b1;
                ram_waddr = pos_m1;
                ram_wdata = val_q;
                count_d   = count_q + CNT_W'(1);
                res_ok_d  = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = cnt_m1;
                idx_d     = cnt_m1;
                state_d   = ST_INS_SHIFT;
              end
            end
          end
          CMD_DELETE: begin
            if (pos_in) begin
              if (pos_x == cnt_x) begin
                // last element: just drop it
                count_d  = count_q - CNT_W'(1);
                res_ok_d = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(pos_x);
                idx_d     = ADDR_W'(pos_x);
                state_d   = ST_DEL_SHIFT;
              end
            end
          end
          CMD_READ: begin
            if (pos_in) begin
              ram_re    = 1'b1;
              ram_raddr = pos_m1;
              state_d   = ST_READ;
            end
          end
          CMD_FIND: begin
            if (count_q != '0) begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              idx_d     = '0;
              state_d   = ST_FIND;
            end
          end
          default: begin
            // unused codes fail with no change
          end
        endcase
      end

      ST_READ: begin
        res_ok_d   = 1'b1;
        res_elem_d = ram_rdata;
        state_d    = ST_DONE;
      end

      // move entry idx up by one, walking down toward the insert point
      ST_INS_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q + ADDR_W'(1);
        ram_wdata = ram_rdata;
        if (idx_q == pos_m1) begin
          state_d = ST_INS_PUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_q - ADDR_W'(1);
          idx_d     = idx_q - ADDR_W'(1);
        end
      end

      ST_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_m1;
        ram_wdata = val_q;
        count_d   = count_q + CNT_W'(1);
        res_ok_d  = 1'b1;
        state_d   = ST_DONE;
      end

      // move entry idx down by one, walking up to the tail
      ST_DEL_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q - ADDR_W'(1);
        ram_wdata = ram_rdata;
        if (idx_q == cnt_m1) begin
          count_d  = count_q - CNT_W'(1);
          res_ok_d = 1'b1;
          state_d  = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_q + ADDR_W'(1);
          idx_d     = idx_q + ADDR_W'(1);
        end
      end

      // linear scan, first match wins
      ST_FIND: begin
        if (ram_rdata == val_q) begin
          res_ok_d   = 1'b1;
          res_fpos_d = POS_W'(CMP_W'(idx_q) + CMP_W'(1));
          state_d    = ST_DONE;
        end else if (idx_q == cnt_m1) begin
          state_d = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_q + ADDR_W'(1);
          idx_d     = idx_q + ADDR_W'(1);
        end
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ok_d        = res_ok_q;
          elem_d      = res_elem_q;
          fpos_d      = res_fpos_q;
          len_d       = LEN_W'(count_q);
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      pos_q       <= '0;
      val_q       <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      res_ok_q    <= 1'b0;
      res_elem_q  <= '0;
      res_fpos_q  <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      elem_q      <= '0;
      fpos_q      <= '0;
      len_q       <= '0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      pos_q       <= pos_d;
      val_q       <= val_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      res_ok_q    <= res_ok_d;
      res_elem_q  <= res_elem_d;
      res_fpos_q  <= res_fpos_d;
      out_valid_q <= out_valid_d;
      ok_q        <= ok_d;
      elem_q      <= elem_d;
      fpos_q      <= fpos_d;
      len_q       <= len_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign elem_out_o  = elem_q;
  assign found_pos_o = fpos_q;
  assign list_len_o  = len_q;

  // checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_x <= CMP_W'(CAPACITY))
    else $error("list count above capacity");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CNT_W'(1)) || (count_q == $past(count_q) - CNT_W'(1)))
    else $error("list count moved by more than one");

  a_write_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CMP_W'(ram_waddr) <= cnt_x))
    else $error("RAM write beyond list tail");

  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && !(out_valid_q && out_stall_i)) |-> (state_q == ST_DONE))
    else $error("result loaded outside done state");

endmodule

`default_nettype wire

// ----- verif/tb_positional_list_engine_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine_unit
// Self-checking bench for the positional list engine. A directed table covers
// the empty list, bad positions, unused commands and signed extremes. A phased
// random run follows: fill-heavy, drain-heavy and mixed traffic. Typed rows
// are checked against their table result, every other result against a shadow
// list kept in the bench. Both channels idle and stall at random. One phase
// holds off the result side for a long time, and the request side pauses now
// and then until every result has come back.
// ----------------------------------------------------------------------------

module tb_positional_list_engine_unit;

  import ple_pkg::*;

  localparam int CAP           = int'(CAPACITY);
  localparam int RANDOM_ITEMS  = 950;
  localparam int MAX_WAIT      = 14;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 100;
  localparam int WATCHDOG_MAX  = 3000;

  // Command codes the block does not define
  localparam logic [CMD_W-1:0] CMD_UNUSED_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  // Random traffic styles
  localparam int STYLE_MIX   = 0;
  localparam int STYLE_FILL  = 1;
  localparam int STYLE_DRAIN = 2;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] elem;
    logic [POS_W-1:0]        fpos;
    logic [LEN_W-1:0]        len;
  } list_result_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic             typed;
    list_result_t     want;
  } directed_row_t;

  // Directed requests; typed rows carry the obvious result, others use the shadow list
  localparam directed_row_t DIRECTED_ROWS [25] = '{
    '{CMD_READ,     7'd1,   32'h0000_0000, 1'b1, '{1'b0, 32'd0, 7'd0, 7'd0}},
    '{CMD_DELETE,   7'd1,   32'h0000_0000, 1'b1, '{1'b0, 32'd0, 7'd0, 7'd0}},
    '{CMD_FIND,     7'd0,   32'h0000_0000, 1'b1, '{1'b0, 32'd0, 7'd0, 7'd0}},
    '{CMD_UNUSED_5, 7'd3,   32'h0000_0009, 1'b1, '{1'b0, 32'd0, 7'd0, 7'd0}},
    '{CMD_UNUSED_7, 7'd127, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd0, 7'd0, 7'd0}},
    '{CMD_APPEND,   7'd0,   32'h7FFF_FFFF, 1'b1, '{1'b1, 32'd0, 7'd0, 7'd1}},
    '{CMD_APPEND,   7'd127, 32'h8000_0000, 1'b1, '{1'b1, 32'd0, 7'd0, 7'd2}},
    '{CMD_INSERT,   7'd0,   32'h0000_0005, 1'b1, '{1'b0, 32'd0, 7'd0, 7'd2}},
    '{CMD_INSERT,   7'd4,   32'h0000_0005, 1'b1, '{1'b0, 32'd0, 7'd0, 7'd2}},
    '{CMD_INSERT,   7'd3,   32'hFFFF_FFFF, 1'b1, '{1'b1, 32'd0, 7'd0, 7'd3}},
    '{CMD_INSERT,   7'd1,   32'h0000_0000, 1'b1, '{1'b1, 32'd0, 7'd0, 7'd4}},
    '{CMD_READ,     7'd1,   32'h0000_0000, 1'b0, '0},
    '{CMD_READ,     7'd4,   32'h0000_0000, 1'b0, '0},
    '{CMD_READ,     7'd5,   32'h0000_0000, 1'b1, '{1'b0, 32'd0, 7'd0, 7'd4}},
    '{CMD_READ,     7'd127, 32'h0000_0000, 1'b1, '{1'b0, 32'd0, 7'd0, 7'd4}},
    '{CMD_FIND,     7'd0,   32'hFFFF_FFFF, 1'b0, '0},
    '{CMD_FIND,     7'd0,   32'h8000_0000, 1'b0, '0},
    '{CMD_FIND,     7'd0,   32'h0000_3039, 1'b1, '{1'b0, 32'd0, 7'd0, 7'd4}},
    '{CMD_APPEND,   7'd0,   32'h7FFF_FFFF, 1'b0, '0},
    '{CMD_FIND,     7'd0,   32'h7FFF_FFFF, 1'b0, '0},
    '{CMD_DELETE,   7'd2,   32'h0000_0000, 1'b0, '0},
    '{CMD_DELETE,   7'd5,   32'h0000_0000, 1'b1, '{1'b0, 32'd0, 7'd0, 7'd4}},
    '{CMD_DELETE,   7'd4,   32'h0000_0000, 1'b0, '0},
    '{CMD_DELETE,   7'd1,   32'h0000_0000, 1'b0, '0},
    '{CMD_UNUSED_6, 7'd1,   32'h0000_0001, 1'b1, '{1'b0, 32'd0, 7'd0, 7'd2}}
  };

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [CMD_W-1:0]        cmd_i       = '0;
  logic [POS_W-1:0]        position_i  = '0;
  logic signed [VAL_W-1:0] value_i     = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    ok_o;
  logic signed [VAL_W-1:0] elem_out_o;
  logic [POS_W-1:0]        found_pos_o;
  logic [LEN_W-1:0]        list_len_o;

  // Shadow copy of the list
  logic signed [VAL_W-1:0] shadow_elems [CAP];
  int                      shadow_count = 0;

  list_result_t pending_results [$];
  int           fail_count   = 0;
  int           result_index = 0;
  bit           quiet_tx     = 1'b0;
  bit           quiet_rx     = 1'b0;
  bit           hold_req     = 1'b0;

  positional_list_engine_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ok_o        (ok_o),
    .elem_out_o  (elem_out_o),
    .found_pos_o (found_pos_o),
    .list_len_o  (list_len_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one command to the shadow list and return its result
  function automatic list_result_t apply_list_command(logic [CMD_W-1:0] cmd,
                                                      logic [POS_W-1:0] pos,
                                                      logic signed [VAL_W-1:0] val);
    list_result_t res;
    int           p;
    int           i;
    res = '0;
    p   = int'(pos);
    case (cmd)
      CMD_APPEND: begin
        if (shadow_count < CAP) begin
          shadow_elems[shadow_count] = val;
          shadow_count++;
          res.ok = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (shadow_count < CAP && p >= 1 && p <= shadow_count + 1) begin
          for (i = shadow_count; i > p - 1; i--) shadow_elems[i] = shadow_elems[i-1];
          shadow_elems[p-1] = val;
          shadow_count++;
          res.ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (p >= 1 && p <= shadow_count) begin
          for (i = p - 1; i + 1 < shadow_count; i++) shadow_elems[i] = shadow_elems[i+1];
          shadow_count--;
          res.ok = 1'b1;
        end
      end
      CMD_READ: begin
        if (p >= 1 && p <= shadow_count) begin
          res.elem = shadow_elems[p-1];
          res.ok   = 1'b1;
        end
      end
      CMD_FIND: begin
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_elems[i] == val) begin
            res.fpos = 7'(i + 1);
            res.ok   = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    res.len = 7'(shadow_count);
    return res;
  endfunction

  // Value source: a stored element (duplicates, find hits), an extreme, or random
  function automatic logic [VAL_W-1:0] pick_value(int from_list_pct);
    int r;
    r = $urandom_range(0, 99);
    if (shadow_count > 0 && r < from_list_pct)
      return shadow_elems[$urandom_range(0, shadow_count - 1)];
    if (r >= 88) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  // Position within 1..hi mostly, with edges and an occasional wild one
  function automatic logic [POS_W-1:0] pick_position(int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)  return 7'($urandom_range(0, 127));
    if (hi < 1)  return 7'($urandom_range(0, 2));
    if (r == 1)  return 7'(hi);
    if (r == 2)  return 7'd1;
    return 7'($urandom_range(1, hi));
  endfunction

  // Build one random request in the given traffic style
  task automatic next_random_request(input int style, output logic [CMD_W-1:0] cmd,
                                     output logic [POS_W-1:0] pos,
                                     output logic [VAL_W-1:0] val);
    int r;
    r     = $urandom_range(0, 99);
    pos   = 7'($urandom_range(0, 127));
    val   = $urandom;
    if (style == STYLE_FILL)
      cmd = (r < 45) ? CMD_APPEND : (r < 75) ? CMD_INSERT : (r < 85) ? CMD_FIND :
            (r < 92) ? CMD_READ : (r < 97) ? CMD_DELETE : CMD_UNUSED_5;
    else if (style == STYLE_DRAIN)
      cmd = (r < 50) ? CMD_DELETE : (r < 62) ? CMD_FIND : (r < 75) ? CMD_READ :
            (r < 85) ? CMD_INSERT : (r < 92) ? CMD_APPEND : CMD_UNUSED_5;
    else
      cmd = (r < 20) ? CMD_APPEND : (r < 40) ? CMD_INSERT : (r < 60) ? CMD_DELETE :
            (r < 75) ? CMD_READ : (r < 90) ? CMD_FIND : CMD_UNUSED_5;
    case (cmd)
      CMD_APPEND: val = pick_value(25);
      CMD_INSERT: begin
        pos = pick_position(shadow_count + 1);
        val = pick_value(25);
      end
      CMD_DELETE,
      CMD_READ:   pos = pick_position(shadow_count);
      CMD_FIND:   val = pick_value(60);
      default: begin
        // Noise: any command code, any position, any value
        cmd   = 3'($urandom_range(0, 7));
      end
    endcase
  endtask

  // Offer one request and wait until it is taken
  task automatic drive_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val, input bit typed,
                               input list_result_t want);
    int           gap;
    list_result_t res;
    gap = quiet_tx ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    res = apply_list_command(cmd, pos, val);
    pending_results.push_back(typed ? want : res);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic bit field_differs(string name, logic signed [VAL_W-1:0] want,
                                       logic signed [VAL_W-1:0] got);
    if (want === got) return 1'b0;
    $display("%0t: result %0d %s mismatch: expected %0d, actual %0d",
             $time, result_index, name, want, got);
    return 1'b1;
  endfunction

  // Result side: random stall per result, long hold-off on request
  int unsigned rx_wait   = 0;
  int unsigned hold_left = 0;

  always @(posedge clk_i) begin
    list_result_t want;
    bit           bad;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result %0d arrived with nothing expected", $time, result_index);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          bad  = field_differs("ok", 32'(want.ok), 32'(ok_o));
          bad |= field_differs("elem_out", want.elem, elem_out_o);
          bad |= field_differs("found_pos", 32'(want.fpos), 32'(found_pos_o));
          bad |= field_differs("list_len", 32'(want.len), 32'(list_len_o));
          if (bad) fail_count++;
        end
        result_index++;
        rx_wait = quiet_rx ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_MAX) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("positional_list_engine_unit verification failed");
    $finish;
  end

  // Stimulus
  initial begin
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int               sent;
    int               phase;
    int               style;
    int               span;
    int               n;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (DIRECTED_ROWS[k])
      drive_request(DIRECTED_ROWS[k].cmd, DIRECTED_ROWS[k].pos, DIRECTED_ROWS[k].val,
                    DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);
    wait_results_drained();

    // Random phases: fill, drain and mixed traffic in turn
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      style    = (phase % 3 == 0) ? STYLE_FILL : (phase % 3 == 1) ? STYLE_DRAIN : STYLE_MIX;
      quiet_rx = (phase % 5 == 2);
      quiet_tx = (phase % 5 == 2) || (phase == 3);
      if (phase == 3) hold_req = 1'b1;
      span = $urandom_range(40, 90);
      for (n = 0; n < span && sent < RANDOM_ITEMS; n++) begin
        next_random_request(style, cmd, pos, val);
        drive_request(cmd, pos, val, 1'b0, '0);
        sent++;
      end
      if (phase % 2 == 1) wait_results_drained();
      phase++;
    end
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;

    // Let the last results arrive, then give stray ones a chance to show
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("positional_list_engine_unit verification clean");
    else
      $display("positional_list_engine_unit verification failed");
    $finish;
  end

endmodule
